// File: hw/rtl/tdp_pkg.sv
// Shared constants, types and generator functions for the ternary dot-product block.
// No dependencies; every other file of the block uses this package.
package tdp_pkg;

    // Default lane count and field widths.
    localparam int LANES_DEF  = 8;
    localparam int TRIT_W     = 16;
    localparam int NV_W       = 4;
    localparam int DOT_W      = 32;
    localparam int ACC_W      = 24;
    localparam int ACC_MAX    = 8388607;
    localparam int CLAMP_W    = 31;
    localparam logic [CLAMP_W-1:0] CLAMP_RESET = 31'd581130733;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] REG_COLLAPSE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SEED     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CLAMP    = 2'd2;

    // Trit codes; the two remaining codes mean zero.
    localparam logic [1:0] TRIT_POS = 2'b01;
    localparam logic [1:0] TRIT_NEG = 2'b11;

    // xorshift32 generator.
    localparam int RNG_W        = 32;
    localparam logic [RNG_W-1:0] SEED_DEFAULT = 32'hdeadbeef;
    localparam int WARMUP_STEPS = 8;

    // Per-item step summary, sized for up to 63 lanes.
    localparam int SLACK_W = 6;
    localparam int STEP_W  = SLACK_W + 1;

    // One item reduced to a saturating update: acc' = clamp(acc + sum,
    // -ACC_MAX + dl, ACC_MAX - dh).
    typedef struct packed {
        logic                     last;
        logic signed [STEP_W-1:0] sum;
        logic [SLACK_W-1:0]       dl;
        logic [SLACK_W-1:0]       dh;
    } t_step;

    function automatic logic [RNG_W-1:0] xs_step(input logic [RNG_W-1:0] x);
        logic [RNG_W-1:0] y;
        y = x ^ (x << 13);
        y = y ^ (y >> 17);
        y = y ^ (y << 5);
        return y;
    endfunction

    function automatic logic [RNG_W-1:0] xs_warm(input logic [RNG_W-1:0] seed);
        logic [RNG_W-1:0] y;
        y = (seed == '0) ? SEED_DEFAULT : seed;
        for (int k = 0; k < WARMUP_STEPS; k++) begin
            y = xs_step(y);
        end
        return y;
    endfunction

endpackage

// File: hw/rtl/tdp_in_if.sv
// Input channel of the ternary dot-product block: trit pairs, lane count, last flag.
// Depends on tdp_pkg for field widths.
interface tdp_in_if;
    logic                          valid;
    logic                          ready;
    logic [tdp_pkg::TRIT_W-1:0]    act_trits;
    logic [tdp_pkg::TRIT_W-1:0]    wgt_trits;
    logic [tdp_pkg::NV_W-1:0]      lanes_valid;
    logic                          last;

    modport source (output valid, act_trits, wgt_trits, lanes_valid, last, input ready);
    modport sink   (input valid, act_trits, wgt_trits, lanes_valid, last, output ready);
endinterface

// File: hw/rtl/tdp_out_if.sv
// Output channel of the ternary dot-product block: one clamped dot product per item with last set.
// Depends on tdp_pkg for the field width.
interface tdp_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [tdp_pkg::DOT_W-1:0]  dot_value;

    modport source (output valid, dot_value, input ready);
    modport sink   (input valid, dot_value, output ready);
endinterface

// File: hw/rtl/tdp_lane.sv
// One lane: decodes a trit pair, forms the product, substitutes a random +-1 for a zero when collapse is on.
// Depends on tdp_pkg for trit codes.
module tdp_lane (
    input  logic              i_act,
    input  logic [1:0]        i_act_code,
    input  logic [1:0]        i_wgt_code,
    input  logic              i_collapse_en,
    input  logic              i_rnd,
    output logic              o_need,
    output logic signed [1:0] o_delta
);

    logic w_a_nz, w_w_nz, w_nz, w_neg;

    assign w_a_nz = (i_act_code == tdp_pkg::TRIT_POS) || (i_act_code == tdp_pkg::TRIT_NEG);
    assign w_w_nz = (i_wgt_code == tdp_pkg::TRIT_POS) || (i_wgt_code == tdp_pkg::TRIT_NEG);
    assign w_nz   = w_a_nz && w_w_nz;
    assign w_neg  = (i_act_code == tdp_pkg::TRIT_NEG) ^ (i_wgt_code == tdp_pkg::TRIT_NEG);

    // A lane that takes part and has a zero product draws one generator step when collapse is enabled.
    assign o_need = i_act && !w_nz && i_collapse_en;

    always_comb begin
        if (!i_act) begin
            o_delta = 2'sd0;
        end else if (w_nz) begin
            o_delta = w_neg ? -2'sd1 : 2'sd1;
        end else if (i_collapse_en) begin
            o_delta = i_rnd ? 2'sd1 : -2'sd1;
        end else begin
            o_delta = 2'sd0;
        end
    end

endmodule

// File: hw/rtl/tdp_front.sv
// Lane stage: LANES tdp_lane copies, the unrolled xorshift chain and the per-item
// saturation summary, registered. Depends on tdp_pkg and tdp_lane.
module tdp_front #(
    parameter int LANES = tdp_pkg::LANES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [tdp_pkg::TRIT_W-1:0]   i_act,
    input  logic [tdp_pkg::TRIT_W-1:0]   i_wgt,
    input  logic [tdp_pkg::NV_W-1:0]     i_nv,
    input  logic                         i_last,
    input  logic                         i_take,
    input  logic                         i_collapse_en,
    input  logic                         i_seed_we,
    input  logic [tdp_pkg::RNG_W-1:0]    i_seed,
    output tdp_pkg::t_step               o_step
);

    localparam int CNT_W   = $clog2(LANES + 1);
    localparam int CHAIN_N = 2 ** CNT_W;

    logic [tdp_pkg::RNG_W-1:0] r_rng;
    logic [tdp_pkg::RNG_W-1:0] w_chain [CHAIN_N];
    logic [LANES-1:0]          w_need;
    logic [LANES-1:0]          w_rnd;
    logic signed [1:0]         w_delta [LANES];
    logic [CNT_W-1:0]          w_cnt;
    logic [CNT_W-1:0]          w_total;
    tdp_pkg::t_step            r_step;
    tdp_pkg::t_step            n_step;

    // w_chain[k] is the generator state after k steps, for k up to LANES; the rest read zero.
    assign w_chain[0] = r_rng;
    for (genvar k = 1; k < CHAIN_N; k++) begin : g_chain
        if (k <= LANES) begin : g_step
            assign w_chain[k] = tdp_pkg::xs_step(w_chain[k-1]);
        end else begin : g_pad
            assign w_chain[k] = '0;
        end
    end

    for (genvar i = 0; i < LANES; i++) begin : g_lane
        logic [1:0] w_ac, w_wc;
        logic       w_en;
        // Lanes above the 16-bit fields read as zero trits.
        if (2 * i + 1 < tdp_pkg::TRIT_W) begin : g_bits
            assign w_ac = i_act[2*i +: 2];
            assign w_wc = i_wgt[2*i +: 2];
        end else begin : g_zero
            assign w_ac = 2'b00;
            assign w_wc = 2'b00;
        end
        assign w_en = (int'(i_nv) > i);

        tdp_lane u_lane (
            .i_act         (w_en),
            .i_act_code    (w_ac),
            .i_wgt_code    (w_wc),
            .i_collapse_en (i_collapse_en),
            .i_rnd         (w_rnd[i]),
            .o_need        (w_need[i]),
            .o_delta       (w_delta[i])
        );
    end

    // The n-th zero lane (ascending) takes bit 0 of the state after n steps.
    always_comb begin
        w_cnt = '0;
        for (int i = 0; i < LANES; i++) begin
            w_rnd[i] = w_chain[CNT_W'(w_cnt + 1'b1)][0];
            w_cnt    = w_cnt + CNT_W'(w_need[i]);
        end
        w_total = w_cnt;
    end

    // Fold the per-lane saturating adds into one sum and two boundary slacks.
    always_comb begin
        logic signed [tdp_pkg::STEP_W-1:0] d;
        logic signed [tdp_pkg::STEP_W-1:0] t_l;
        logic signed [tdp_pkg::STEP_W-1:0] t_h;
        n_step.last = i_last;
        n_step.sum  = '0;
        n_step.dl   = '0;
        n_step.dh   = '0;
        for (int i = 0; i < LANES; i++) begin
            d   = tdp_pkg::STEP_W'(w_delta[i]);
            t_l = $signed({1'b0, n_step.dl}) + d;
            t_h = $signed({1'b0, n_step.dh}) - d;
            n_step.sum = n_step.sum + d;
            n_step.dl  = t_l[tdp_pkg::STEP_W-1] ? '0 : t_l[tdp_pkg::SLACK_W-1:0];
            n_step.dh  = t_h[tdp_pkg::STEP_W-1] ? '0 : t_h[tdp_pkg::SLACK_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rng <= tdp_pkg::xs_warm('0);
        end else if (i_seed_we) begin
            r_rng <= tdp_pkg::xs_warm(i_seed);
        end else if (i_take) begin
            r_rng <= w_chain[w_total];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_step <= n_step;
        end
    end

    assign o_step = r_step;

endmodule

// File: hw/rtl/tdp_merge.sv
// Merge stage: applies each item's summary to the saturating accumulator, then
// clamps a finished sum to +-clamp_limit into the output register. Depends on tdp_pkg.
module tdp_merge (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_step_load,
    input  logic                               i_out_load,
    input  tdp_pkg::t_step                     i_step,
    input  logic [tdp_pkg::CLAMP_W-1:0]        i_clamp_limit,
    output logic signed [tdp_pkg::DOT_W-1:0]   o_dot
);

    localparam int SAT_W = tdp_pkg::ACC_W + 2;
    localparam int CMP_W = tdp_pkg::DOT_W + 1;
    localparam logic signed [SAT_W-1:0] SAT_MAX = SAT_W'(tdp_pkg::ACC_MAX);

    logic signed [tdp_pkg::ACC_W-1:0] r_acc;
    logic signed [tdp_pkg::ACC_W-1:0] r_fin;
    logic signed [tdp_pkg::DOT_W-1:0] r_dot;
    logic signed [SAT_W-1:0]          w_sum, w_lo, w_hi, w_sat;
    logic signed [CMP_W-1:0]          w_fin, w_lim, w_out;

    assign w_sum = SAT_W'(r_acc) + SAT_W'(i_step.sum);
    assign w_lo  = -SAT_MAX + $signed(SAT_W'(i_step.dl));
    assign w_hi  = SAT_MAX - $signed(SAT_W'(i_step.dh));

    always_comb begin
        if (w_sum < w_lo) begin
            w_sat = w_lo;
        end else if (w_sum > w_hi) begin
            w_sat = w_hi;
        end else begin
            w_sat = w_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_step_load) begin
            r_acc <= i_step.last ? '0 : w_sat[tdp_pkg::ACC_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step_load && i_step.last) begin
            r_fin <= w_sat[tdp_pkg::ACC_W-1:0];
        end
    end

    // Output clamp; a zero limit forces zero.
    assign w_fin = CMP_W'(r_fin);
    assign w_lim = $signed(CMP_W'(i_clamp_limit));

    always_comb begin
        if (w_fin > w_lim) begin
            w_out = w_lim;
        end else if (w_fin < -w_lim) begin
            w_out = -w_lim;
        end else begin
            w_out = w_fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_out_load) begin
            r_dot <= w_out[tdp_pkg::DOT_W-1:0];
        end
    end

    assign o_dot = r_dot;

endmodule

// File: hw/rtl/ternary_dot_product_with_zero_collapse.sv
// Top level of the ternary dot-product block: config registers, stage control,
// lane stage and merge stage. Depends on tdp_pkg, tdp_in_if, tdp_out_if, tdp_front, tdp_merge.
//
//   Channel    Dir  Payload                                        Handshake
//   i_in_ch    in   act_trits, wgt_trits, lanes_valid, last        valid/ready
//   o_out_ch   out  dot_value (one per item with last set)         valid/ready
//   i_cfg_*    in   idx 0 collapse_enable, 1 rng_seed, 2 clamp     write enable only
//
// One item per cycle unless a stalled output backs up. After its last item is accepted,
// a result passes the lane stage (trit products, xorshift chain, summary), accumulator, clamp.
// The lane stage and the accumulator add/saturate set the cycle time.
// Reset clears all stages and the accumulator and warms the generator from 0xdeadbeef.
// A stalled output backs up through the stages; items without last still drain into
// the accumulator while a finished result waits.
module ternary_dot_product_with_zero_collapse #(
    parameter int LANES = tdp_pkg::LANES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    tdp_in_if.sink                            i_in_ch,
    tdp_out_if.source                         o_out_ch,
    input  logic                              i_cfg_we,
    input  logic [tdp_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [tdp_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    logic                          r_collapse_en;
    logic [tdp_pkg::CLAMP_W-1:0]   r_clamp_limit;
    logic                          r_s1_vld, r_s2_vld, r_out_vld;
    logic                          w_seed_we;
    logic                          w_out_free, w_s2_move, w_s2_free, w_s1_move, w_take;
    tdp_pkg::t_step                w_step;

    // Configuration.
    assign w_seed_we = i_cfg_we && (i_cfg_idx == tdp_pkg::REG_SEED);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_collapse_en <= 1'b0;
            r_clamp_limit <= tdp_pkg::CLAMP_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tdp_pkg::REG_COLLAPSE: r_collapse_en <= i_cfg_data[0];
                tdp_pkg::REG_CLAMP:    r_clamp_limit <= i_cfg_data[tdp_pkg::CLAMP_W-1:0];
                default: ;
            endcase
        end
    end

    // Stage control.
    assign w_out_free = !r_out_vld || o_out_ch.ready;
    assign w_s2_move  = r_s2_vld && w_out_free;
    assign w_s2_free  = !r_s2_vld || w_s2_move;
    assign w_s1_move  = r_s1_vld && (w_s2_free || !w_step.last);
    assign i_in_ch.ready = !r_s1_vld || w_s1_move;
    assign w_take     = i_in_ch.valid && i_in_ch.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_take) begin
                r_s1_vld <= 1'b1;
            end else if (w_s1_move) begin
                r_s1_vld <= 1'b0;
            end
            if (w_s1_move && w_step.last) begin
                r_s2_vld <= 1'b1;
            end else if (w_s2_move) begin
                r_s2_vld <= 1'b0;
            end
            if (w_s2_move) begin
                r_out_vld <= 1'b1;
            end else if (o_out_ch.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    tdp_front #(.LANES(LANES)) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_act         (i_in_ch.act_trits),
        .i_wgt         (i_in_ch.wgt_trits),
        .i_nv          (i_in_ch.lanes_valid),
        .i_last        (i_in_ch.last),
        .i_take        (w_take),
        .i_collapse_en (r_collapse_en),
        .i_seed_we     (w_seed_we),
        .i_seed        (i_cfg_data),
        .o_step        (w_step)
    );

    tdp_merge u_merge (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step_load   (w_s1_move),
        .i_out_load    (w_s2_move),
        .i_step        (w_step),
        .i_clamp_limit (r_clamp_limit),
        .o_dot         (o_out_ch.dot_value)
    );

    assign o_out_ch.valid = r_out_vld;

    // A finished sum never lands on a result that has not moved on.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s1_move && w_step.last) |-> (!r_s2_vld || w_s2_move))
        else $error("finished sum overwrote a pending result");

    // A result leaving the merge stage shows on the output next cycle.
    a_out_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s2_move |=> r_out_vld)
        else $error("result lost between merge and output");

    // Reset empties every stage.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!r_s1_vld && !r_s2_vld && !r_out_vld))
        else $error("stage valid set after reset");

endmodule

// File: test/tb_ternary_dot_product_with_zero_collapse.sv
// Testbench for the ternary dot-product block with zero-product collapse.
// Needs tdp_pkg, tdp_in_if, tdp_out_if and the block's RTL; checks each
// clamped dot product against a cycle-free model of the trit math.
`timescale 1ns / 1ps

typedef struct packed {
    logic [tdp_pkg::TRIT_W-1:0] act;
    logic [tdp_pkg::TRIT_W-1:0] wgt;
    logic [tdp_pkg::NV_W-1:0]   nv;
    logic                       last;
} t_trit_item;

class dot_scoreboard;
    logic                         collapse_en;
    logic [tdp_pkg::RNG_W-1:0]    seed;
    logic [tdp_pkg::CLAMP_W-1:0]  clamp;
    logic [tdp_pkg::RNG_W-1:0]    rng;
    int                           acc;
    logic signed [tdp_pkg::DOT_W-1:0] dot_q[$];
    int errors;
    int n_items;
    int n_dots;
    int n_draws;

    function new();
        errors  = 0;
        n_items = 0;
        n_dots  = 0;
        n_draws = 0;
        collapse_en = 1'b0;
        seed  = '0;
        clamp = tdp_pkg::CLAMP_RESET;
        acc   = 0;
        reseed();
    endfunction

    function logic [31:0] xorshift(input logic [31:0] s);
        logic [31:0] t;
        t = s ^ (s << 13);
        t = t ^ (t >> 17);
        return t ^ (t << 5);
    endfunction

    function void reseed();
        rng = (seed == '0) ? tdp_pkg::SEED_DEFAULT : seed;
        repeat (tdp_pkg::WARMUP_STEPS) rng = xorshift(rng);
    endfunction

    function int trit(input logic [1:0] code);
        if (code == tdp_pkg::TRIT_POS) return 1;
        if (code == tdp_pkg::TRIT_NEG) return -1;
        return 0;
    endfunction

    function void write_reg(input logic [tdp_pkg::CFG_IDX_W-1:0] idx,
                            input logic [tdp_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            tdp_pkg::REG_COLLAPSE: collapse_en = data[0];
            tdp_pkg::REG_SEED: begin
                seed = data;
                reseed();
            end
            tdp_pkg::REG_CLAMP: clamp = data[tdp_pkg::CLAMP_W-1:0];
            default: ;
        endcase
    endfunction

    // Called once per accepted input item.
    function void note_item(input t_trit_item it);
        int n;
        int prod;
        int lim;
        int v;
        n = (it.nv > tdp_pkg::LANES_DEF) ? tdp_pkg::LANES_DEF : int'(it.nv);
        for (int lane = 0; lane < n; lane++) begin
            prod = trit(it.act[2*lane +: 2]) * trit(it.wgt[2*lane +: 2]);
            if (prod == 0 && collapse_en) begin
                rng = xorshift(rng);
                prod = rng[0] ? 1 : -1;
                n_draws++;
            end
            acc += prod;
            if (acc > tdp_pkg::ACC_MAX) acc = tdp_pkg::ACC_MAX;
            if (acc < -tdp_pkg::ACC_MAX) acc = -tdp_pkg::ACC_MAX;
        end
        n_items++;
        if (it.last) begin
            lim = int'(clamp);
            v = acc;
            if (v > lim) v = lim;
            if (v < -lim) v = -lim;
            dot_q.push_back(v);
            acc = 0;
        end
    endfunction

    function void check_result(input logic signed [tdp_pkg::DOT_W-1:0] got);
        logic signed [tdp_pkg::DOT_W-1:0] want;
        if (dot_q.size() == 0) begin
            $error("dot_value: expected none, actual %0d", got);
            errors++;
            return;
        end
        want = dot_q.pop_front();
        n_dots++;
        if (got !== want) begin
            $error("dot_value: expected %0d, actual %0d", want, got);
            errors++;
        end
    endfunction

    function int pending();
        return dot_q.size();
    endfunction
endclass

module tb_ternary_dot_product_with_zero_collapse;

    localparam logic [tdp_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int IDLE_LIMIT   = 600;
    localparam int SETTLE_CYC   = 8;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 240;

    logic i_clk;
    logic i_rst_n;
    logic                           i_cfg_we;
    logic [tdp_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [tdp_pkg::CFG_DATA_W-1:0] i_cfg_data;

    tdp_in_if  in_ch();
    tdp_out_if out_ch();

    ternary_dot_product_with_zero_collapse dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_ch    (in_ch),
        .o_out_ch   (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    dot_scoreboard sb;
    int burst_left;
    int idle_cycles;
    int rx_cnt;
    int rx_mode;
    int n_settings;

    always #5 i_clk = ~i_clk;

    // Result side: check, then pick the next ready value.
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            sb.check_result(out_ch.dot_value);
        end
        rx_cnt <= rx_cnt + 1;
        if (rx_cnt % 50 == 0) rx_mode <= $urandom_range(0, 3);
        case (rx_mode)
            0: out_ch.ready <= 1'b1;
            1: out_ch.ready <= 1'($urandom_range(0, 1));
            2: out_ch.ready <= (rx_cnt % 4 == 0);
            default: out_ch.ready <= rx_cnt[3];
        endcase
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
            || i_cfg_we) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $error("stalled for %0d cycles with %0d results outstanding",
                   idle_cycles, sb.pending());
            $display("RESULT: ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic write_reg(input logic [tdp_pkg::CFG_IDX_W-1:0] idx,
                             input logic [tdp_pkg::CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.write_reg(idx, data);
    endtask

    // Hold off the sender until every dot product is out and the pipe is empty.
    task automatic settle();
        in_ch.valid <= 1'b0;
        burst_left = 0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic send_item(input t_trit_item it);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
            gap = $urandom_range(1, 6);
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        burst_left--;
        in_ch.valid       <= 1'b1;
        in_ch.act_trits   <= it.act;
        in_ch.wgt_trits   <= it.wgt;
        in_ch.lanes_valid <= it.nv;
        in_ch.last        <= it.last;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_item(it);
    endtask

    task automatic send(input logic [15:0] act, input logic [15:0] wgt,
                        input logic [3:0] nv, input logic last);
        t_trit_item it;
        it.act  = act;
        it.wgt  = wgt;
        it.nv   = nv;
        it.last = last;
        send_item(it);
    endtask

    // style 0-1: mostly zero trits, 2: no zero codes, else uniform bits
    function automatic logic [15:0] rand_trits(input int style);
        logic [15:0] w;
        w = 16'($urandom);
        if (style <= 1) begin
            w = w & 16'($urandom) & 16'($urandom);
        end else if (style == 2) begin
            for (int l = 0; l < tdp_pkg::LANES_DEF; l++) begin
                w[2*l +: 2] = $urandom_range(0, 1) ? tdp_pkg::TRIT_POS : tdp_pkg::TRIT_NEG;
            end
        end
        return w;
    endfunction

    task automatic run_dots(input int n_target);
        int sent;
        int len;
        int style;
        int pick;
        t_trit_item it;
        sent = 0;
        while (sent < n_target) begin
            pick = $urandom_range(0, 19);
            len = (pick < 14) ? $urandom_range(1, 8) :
                  (pick < 19) ? $urandom_range(9, 30) : 1;
            style = $urandom_range(0, 9);
            for (int k = 0; k < len; k++) begin
                it.act = rand_trits(style);
                it.wgt = rand_trits(style);
                it.nv  = ($urandom_range(0, 6) == 0) ? 4'($urandom_range(0, 15))
                                                     : 4'($urandom_range(1, 8));
                it.last = (k == len - 1);
                send_item(it);
            end
            sent += len;
            if ($urandom_range(0, 39) == 0) settle();
        end
    endtask

    task automatic set_phase(input int p);
        logic [31:0] clamp_val;
        settle();
        case (p)
            0: begin
                write_reg(tdp_pkg::REG_COLLAPSE, 32'd1);
                write_reg(tdp_pkg::REG_SEED, 32'd0);
                write_reg(tdp_pkg::REG_CLAMP, 32'h7fff_ffff);
            end
            1: begin
                write_reg(tdp_pkg::REG_COLLAPSE, 32'hffff_fffe);
                write_reg(tdp_pkg::REG_SEED, 32'hffff_ffff);
                write_reg(tdp_pkg::REG_CLAMP, 32'd1);
            end
            2: begin
                write_reg(tdp_pkg::REG_COLLAPSE, 32'd1);
                write_reg(tdp_pkg::REG_CLAMP, 32'd0);
            end
            default: begin
                clamp_val = $urandom_range(0, 1) ? $urandom_range(1, 40) : $urandom;
                write_reg(tdp_pkg::REG_COLLAPSE, $urandom);
                if ($urandom_range(0, 2) != 0) write_reg(tdp_pkg::REG_SEED, $urandom);
                write_reg(tdp_pkg::REG_CLAMP, clamp_val);
            end
        endcase
        n_settings++;
    endtask

    initial begin
        sb = new();
        i_clk   = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        in_ch.valid       = 1'b0;
        in_ch.act_trits   = '0;
        in_ch.wgt_trits   = '0;
        in_ch.lanes_valid = '0;
        in_ch.last        = 1'b0;
        out_ch.ready = 1'b0;
        burst_left  = 0;
        idle_cycles = 0;
        rx_cnt  = 0;
        rx_mode = 0;
        n_settings = 1;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: collapse off, generator warmed from the default seed.
        send(16'h5555, 16'h5555, 4'd8, 1'b0);
        send(16'hffff, 16'hffff, 4'd8, 1'b0);
        send(16'h5555, 16'hffff, 4'd8, 1'b0);
        send(16'haaaa, 16'h5555, 4'd8, 1'b0);
        send(16'h0000, 16'hffff, 4'd15, 1'b0);
        send(16'h5555, 16'h5555, 4'd0, 1'b1);
        send(16'h0000, 16'h0000, 4'd0, 1'b1);
        send(16'h5555, 16'h5555, 4'd1, 1'b1);
        send(16'hffff, 16'h5555, 4'd9, 1'b1);

        // Collapse on with the zero seed and a tight clamp; index 3 must be a no-op.
        settle();
        write_reg(REG_UNUSED, 32'hffff_ffff);
        write_reg(tdp_pkg::REG_COLLAPSE, 32'd1);
        write_reg(tdp_pkg::REG_SEED, 32'd0);
        write_reg(tdp_pkg::REG_CLAMP, 32'd3);
        n_settings++;
        send(16'h0000, 16'h0000, 4'd8, 1'b0);
        send(16'haaaa, 16'haaaa, 4'd8, 1'b1);
        send(16'h5555, 16'h5555, 4'd8, 1'b1);
        send(16'hffff, 16'h5555, 4'd8, 1'b1);
        send(16'h1234, 16'hfedc, 4'd12, 1'b1);

        settle();
        write_reg(tdp_pkg::REG_CLAMP, 32'd0);
        n_settings++;
        send(16'h5555, 16'h5555, 4'd8, 1'b1);
        send(16'h0000, 16'h0000, 4'd8, 1'b1);

        settle();
        write_reg(tdp_pkg::REG_SEED, 32'hffff_ffff);
        write_reg(tdp_pkg::REG_CLAMP, 32'h7fff_ffff);
        n_settings++;
        send(16'h0000, 16'h0000, 4'd4, 1'b0);
        send(16'h00ff, 16'hff00, 4'd8, 1'b1);
        send(16'h0000, 16'h0000, 4'd0, 1'b1);

        for (int p = 0; p < PHASES; p++) begin
            set_phase(p);
            run_dots(PHASE_ITEMS);
        end

        settle();
        $display("Sent %0d items over %0d register settings: %0d dot products checked,",
                 sb.n_items, n_settings, sb.n_dots);
        $display("%0d zero products replaced by generator draws.", sb.n_draws);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
